@@ rtl/core/uart_fractional_baud_divisor_search_top_assert.svh @@
// assertion macros for the top-level rtl
`ifndef UART_FRACTIONAL_BAUD_DIVISOR_SEARCH_TOP_ASSERT_SVH
`define UART_FRACTIONAL_BAUD_DIVISOR_SEARCH_TOP_ASSERT_SVH

// same-cycle implication
`define UFBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UFBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ufbd_pkg.sv @@
package ufbd_pkg;

   localparam int BAUD_W      = 24;
   localparam int CLK_W       = 29;
   localparam int DVD_W       = 32;
   localparam int DIVR_W      = 24;
   localparam int DIV_W       = 17;
   localparam int NIB_W       = 4;
   localparam int FRAC_BITS   = 15;
   localparam int ERR_W       = 16;
   localparam int OS_SHIFT    = 4;
   localparam int PRE_SHIFT   = 7;
   localparam int Q_SHIFT     = 8;

   localparam logic [CLK_W-1:0] CLK_RESET = 29'd204000000;
   localparam logic [NIB_W-1:0] MUL_EXACT = 4'd1;
   localparam logic [NIB_W-1:0] ADD_EXACT = 4'd0;
   localparam logic [NIB_W-1:0] MUL_FIRST = 4'd2;
   localparam logic [NIB_W-1:0] ADD_FIRST = 4'd1;
   localparam logic [NIB_W-1:0] MUL_MAX   = 4'd15;
   localparam logic [ERR_W-1:0] ERR_INIT  = '1;

   // floor(32768 / m): added to the scale fraction each time divadd steps by one
   function automatic logic [FRAC_BITS-1:0] step_q(input logic [NIB_W-1:0] m);
      logic [FRAC_BITS-1:0] q;
      case (m)
         4'd2:    q = 15'd16384;
         4'd3:    q = 15'd10922;
         4'd4:    q = 15'd8192;
         4'd5:    q = 15'd6553;
         4'd6:    q = 15'd5461;
         4'd7:    q = 15'd4681;
         4'd8:    q = 15'd4096;
         4'd9:    q = 15'd3640;
         4'd10:   q = 15'd3276;
         4'd11:   q = 15'd2978;
         4'd12:   q = 15'd2730;
         4'd13:   q = 15'd2520;
         4'd14:   q = 15'd2340;
         4'd15:   q = 15'd2184;
         default: q = '0;
      endcase
      return q;
   endfunction

   // 32768 mod m
   function automatic logic [NIB_W-1:0] step_r(input logic [NIB_W-1:0] m);
      logic [NIB_W-1:0] r;
      case (m)
         4'd3:    r = 4'd2;
         4'd5:    r = 4'd3;
         4'd6:    r = 4'd2;
         4'd7:    r = 4'd1;
         4'd9:    r = 4'd8;
         4'd10:   r = 4'd8;
         4'd11:   r = 4'd10;
         4'd12:   r = 4'd8;
         4'd13:   r = 4'd8;
         4'd14:   r = 4'd8;
         4'd15:   r = 4'd8;
         default: r = '0;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [DIVR_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [DVD_W-1:0]  quotient;
      logic [DIVR_W-1:0] remainder;
   } div_res_type;

   typedef struct packed {
      logic [DIV_W-1:0] integer_divisor;
      logic [NIB_W-1:0] frac_mul;
      logic [NIB_W-1:0] frac_divadd;
   } result_type;

endpackage

@@ rtl/core/ufbd_req_if.sv @@
interface ufbd_req_if;
   logic                           valid;
   logic                           ready;
   logic [ufbd_pkg::BAUD_W-1:0]    baud_rate;

   modport source (output valid, output baud_rate, input ready);
   modport sink   (input valid, input baud_rate, output ready);
endinterface

@@ rtl/core/ufbd_rsp_if.sv @@
interface ufbd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ufbd_pkg::DIV_W-1:0]     integer_divisor;
   logic [ufbd_pkg::NIB_W-1:0]     frac_mul;
   logic [ufbd_pkg::NIB_W-1:0]     frac_divadd;

   modport source (output valid, output integer_divisor, output frac_mul,
                   output frac_divadd, input ready);
   modport sink   (input valid, input integer_divisor, input frac_mul,
                   input frac_divadd, output ready);
endinterface

@@ rtl/core/uart_fractional_baud_divisor_search_top.sv @@
// channel | direction | transaction
// req_if  | in        | baud_rate, taken when valid and ready
// rsp_if  | out       | integer_divisor, frac_mul, frac_divadd
// csr     | in        | peripheral clock in Hz, written when csr_wr_en
//
// one shared 32-step restoring divider does all the work, one quotient bit a cycle
// the clock/baud ratio comes first; an exact ratio skips the search and goes from ST_RATIO to ST_DONE
// otherwise 105 mul/divadd trials follow one at a time, each started in ST_LAUNCH and judged in ST_TRIAL
// req_ready is low from acceptance until the result moves to the output register
// a finished result waits in the output register, the next transaction may start meanwhile
// reset (synchronous) loads the clock register with 204 MHz and empties the output
`include "uart_fractional_baud_divisor_search_top_assert.svh"

module uart_fractional_baud_divisor_search_top (
   input  logic                       clock,
   input  logic                       reset,
   ufbd_req_if.sink                   req_if,
   ufbd_rsp_if.source                 rsp_if,
   input  logic                       csr_wr_en,
   input  logic [ufbd_pkg::CLK_W-1:0] csr_wr_data
);

   logic [ufbd_pkg::CLK_W-1:0] clk_hz_ff, clk_hz_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   ufbd_pkg::result_type       rsp_data_ff, rsp_data_in;
   ufbd_pkg::result_type       result;
   ufbd_pkg::div_cmd_type      div_cmd;
   ufbd_pkg::div_res_type      div_res;
   logic                       load;

   ufbd_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   ufbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .clk_hz    (clk_hz_ff),
      .req_valid (req_if.valid),
      .baud_rate (req_if.baud_rate),
      .req_ready (req_if.ready),
      .slot_free (!rsp_valid_ff),
      .load      (load),
      .result    (result),
      .div_cmd   (div_cmd),
      .div_res   (div_res)
   );

   always_comb begin
      clk_hz_in    = csr_wr_en ? csr_wr_data : clk_hz_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff    <= ufbd_pkg::CLK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clk_hz_ff    <= clk_hz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.integer_divisor = rsp_data_ff.integer_divisor;
   assign rsp_if.frac_mul        = rsp_data_ff.frac_mul;
   assign rsp_if.frac_divadd     = rsp_data_ff.frac_divadd;

   `UFBD_ASSERT_NOW(a_load_into_empty, clock, reset, load, !rsp_valid_ff,
      "result loaded over a waiting transaction")
   `UFBD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_if.valid && req_if.ready,
      !req_if.ready, "ready stayed high after acceptance")
   `UFBD_ASSERT_NOW(a_divadd_below_mul, clock, reset, rsp_valid_ff,
      rsp_data_ff.frac_divadd < rsp_data_ff.frac_mul, "divadd not below mul")
   `UFBD_ASSERT_NOW(a_exact_has_no_add, clock, reset,
      rsp_valid_ff && (rsp_data_ff.frac_mul == ufbd_pkg::MUL_EXACT),
      rsp_data_ff.frac_divadd == ufbd_pkg::ADD_EXACT, "exact ratio with nonzero divadd")

endmodule

@@ rtl/core/ufbd_div.sv @@
module ufbd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ufbd_pkg::div_cmd_type cmd,
   output ufbd_pkg::div_res_type res
);

   localparam int CNT_W = $clog2(ufbd_pkg::DVD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ufbd_pkg::DVD_W - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [ufbd_pkg::DVD_W-1:0]    quo_ff, quo_in;
   logic [ufbd_pkg::DIVR_W-1:0]   rem_ff, rem_in;
   logic [ufbd_pkg::DIVR_W-1:0]   dvs_ff, dvs_in;
   logic [ufbd_pkg::DIVR_W:0]     trial;
   logic                          fits;

   // one restoring step per cycle, quotient bits shift in behind the dividend
   assign trial = {rem_ff, quo_ff[ufbd_pkg::DVD_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ufbd_pkg::DVD_W-2:0], fits};
         rem_in = fits ? ufbd_pkg::DIVR_W'(trial - {1'b0, dvs_ff})
                       : trial[ufbd_pkg::DIVR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign res.done      = done_ff;
   assign res.quotient  = quo_ff;
   assign res.remainder = rem_ff;

endmodule

@@ rtl/core/ufbd_ctrl.sv @@
module ufbd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ufbd_pkg::CLK_W-1:0]  clk_hz,
   input  logic                        req_valid,
   input  logic [ufbd_pkg::BAUD_W-1:0] baud_rate,
   output logic                        req_ready,
   input  logic                        slot_free,
   output logic                        load,
   output ufbd_pkg::result_type        result,
   output ufbd_pkg::div_cmd_type       div_cmd,
   input  ufbd_pkg::div_res_type       div_res
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATIO,
      ST_LAUNCH,
      ST_TRIAL,
      ST_DONE
   } state_type;

   state_type                       state_ff, state_in;
   logic [ufbd_pkg::DVD_W-1:0]      ratio_ff, ratio_in;
   logic [ufbd_pkg::NIB_W-1:0]      mul_ff, mul_in;
   logic [ufbd_pkg::NIB_W-1:0]      add_ff, add_in;
   logic [ufbd_pkg::FRAC_BITS-1:0]  frac_ff, frac_in;
   logic [ufbd_pkg::NIB_W-1:0]      frem_ff, frem_in;
   logic [ufbd_pkg::ERR_W-1:0]      best_err_ff, best_err_in;
   logic [ufbd_pkg::DIV_W-1:0]      best_div_ff, best_div_in;
   logic [ufbd_pkg::NIB_W-1:0]      best_mul_ff, best_mul_in;
   logic [ufbd_pkg::NIB_W-1:0]      best_add_ff, best_add_in;

   logic [ufbd_pkg::DVD_W-1:0]      ratio_new;
   logic [ufbd_pkg::ERR_W-1:0]      err;
   logic [ufbd_pkg::NIB_W:0]        rem_sum;
   logic                            rem_wrap;
   logic [ufbd_pkg::NIB_W-1:0]      mul_next;
   logic                            accept;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE);
   assign load      = (state_ff == ST_DONE) && slot_free;

   // ratio = quotient << 8, low 32 bits kept
   assign ratio_new = {div_res.quotient[ufbd_pkg::DVD_W-ufbd_pkg::Q_SHIFT-1:0],
                       {ufbd_pkg::Q_SHIFT{1'b0}}};
   assign err       = div_res.remainder[ufbd_pkg::ERR_W-1:0];
   assign rem_sum   = {1'b0, frem_ff} + {1'b0, ufbd_pkg::step_r(mul_ff)};
   assign rem_wrap  = rem_sum >= {1'b0, mul_ff};
   assign mul_next  = mul_ff + 1'b1;

   always_comb begin
      div_cmd.start = accept || (state_ff == ST_LAUNCH);
      if (state_ff == ST_IDLE) begin
         div_cmd.dividend = {clk_hz[ufbd_pkg::CLK_W-1:ufbd_pkg::OS_SHIFT],
                             {ufbd_pkg::PRE_SHIFT{1'b0}}};
         div_cmd.divisor  = baud_rate;
      end else begin
         div_cmd.dividend = ratio_ff;
         div_cmd.divisor  = ufbd_pkg::DIVR_W'({1'b1, frac_ff});
      end
   end

   always_comb begin
      state_in    = state_ff;
      ratio_in    = ratio_ff;
      mul_in      = mul_ff;
      add_in      = add_ff;
      frac_in     = frac_ff;
      frem_in     = frem_ff;
      best_err_in = best_err_ff;
      best_div_in = best_div_ff;
      best_mul_in = best_mul_ff;
      best_add_in = best_add_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_RATIO;
         end
         ST_RATIO: begin
            if (div_res.done) begin
               ratio_in    = ratio_new;
               best_div_in = ratio_new[ufbd_pkg::DVD_W-1:ufbd_pkg::FRAC_BITS];
               best_mul_in = ufbd_pkg::MUL_EXACT;
               best_add_in = ufbd_pkg::ADD_EXACT;
               best_err_in = ufbd_pkg::ERR_INIT;
               mul_in      = ufbd_pkg::MUL_FIRST;
               add_in      = ufbd_pkg::ADD_FIRST;
               frac_in     = ufbd_pkg::step_q(ufbd_pkg::MUL_FIRST);
               frem_in     = ufbd_pkg::step_r(ufbd_pkg::MUL_FIRST);
               if (ratio_new[ufbd_pkg::FRAC_BITS-1:0] == '0) state_in = ST_DONE;
               else state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in = ST_TRIAL;
         end
         ST_TRIAL: begin
            if (div_res.done) begin
               if (err < best_err_ff) begin
                  best_err_in = err;
                  best_div_in = div_res.quotient[ufbd_pkg::DIV_W-1:0];
                  best_mul_in = mul_ff;
                  best_add_in = add_ff;
               end
               state_in = ST_LAUNCH;
               if (ufbd_pkg::NIB_W'(add_ff + 1'b1) != mul_ff) begin
                  // floor((a+1)*32768/m) from floor(a*32768/m) and its remainder
                  add_in  = add_ff + 1'b1;
                  frac_in = frac_ff + ufbd_pkg::step_q(mul_ff)
                          + ufbd_pkg::FRAC_BITS'(rem_wrap);
                  frem_in = rem_wrap ? ufbd_pkg::NIB_W'(rem_sum - {1'b0, mul_ff})
                                     : rem_sum[ufbd_pkg::NIB_W-1:0];
               end else if (mul_ff == ufbd_pkg::MUL_MAX) begin
                  state_in = ST_DONE;
               end else begin
                  mul_in  = mul_next;
                  add_in  = ufbd_pkg::ADD_FIRST;
                  frac_in = ufbd_pkg::step_q(mul_next);
                  frem_in = ufbd_pkg::step_r(mul_next);
               end
            end
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ratio_ff    <= ratio_in;
      mul_ff      <= mul_in;
      add_ff      <= add_in;
      frac_ff     <= frac_in;
      frem_ff     <= frem_in;
      best_err_ff <= best_err_in;
      best_div_ff <= best_div_in;
      best_mul_ff <= best_mul_in;
      best_add_ff <= best_add_in;
   end

   assign result.integer_divisor = best_div_ff;
   assign result.frac_mul        = best_mul_ff;
   assign result.frac_divadd     = best_add_ff;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import ufbd_pkg::*;

   localparam int STALL_LIMIT = 20000;

   class baud_divisor_scoreboard;
      result_type expected_results[$];
      int mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      // clock/16 << 7, divided by the baud rate, << 8: a 17.15 ratio, then the mul/divadd search
      function result_type predict_divisor(input logic [CLK_W-1:0] clk_hz,
                                           input logic [BAUD_W-1:0] baud);
         logic [31:0] num;
         logic [31:0] quot;
         logic [31:0] ratio;
         logic [31:0] scale;
         logic [31:0] div_try;
         logic [31:0] err;
         logic [31:0] best_err;
         logic [31:0] mv;
         logic [31:0] av;
         result_type r;
         num = {7'd0, clk_hz[CLK_W-1:4]} << 7;
         // a zero baud rate makes the divider answer all ones
         quot = (baud == '0) ? 32'hFFFF_FFFF : num / {8'd0, baud};
         ratio = quot << 8;
         r.integer_divisor = ratio[31:15];
         r.frac_mul = MUL_EXACT;
         r.frac_divadd = ADD_EXACT;
         best_err = 32'hFFFF_FFFF;
         if (ratio[14:0] != '0) begin
            for (mv = 2; mv <= 15; mv++) begin
               for (av = 1; av < mv; av++) begin
                  scale = 32'd32768 + ((av << 15) / mv);
                  div_try = ratio / scale;
                  err = ratio - div_try * scale;
                  if (err < best_err) begin
                     best_err = err;
                     r.integer_divisor = div_try[DIV_W-1:0];
                     r.frac_mul = mv[NIB_W-1:0];
                     r.frac_divadd = av[NIB_W-1:0];
                  end
               end
            end
         end
         return r;
      endfunction

      function void note_baud_request(input logic [CLK_W-1:0] clk_hz,
                                      input logic [BAUD_W-1:0] baud);
         expected_results.push_back(predict_divisor(clk_hz, baud));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      task report_mismatch(input string what);
         $display("mismatch at %0t ns: %s", $time, what);
         mismatch_count++;
      endtask

      task check_divisor_result(input result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result div %0d mul %0d add %0d",
                                      got.integer_divisor, got.frac_mul, got.frac_divadd));
            return;
         end
         want = expected_results.pop_front();
         if (got.integer_divisor !== want.integer_divisor)
            report_mismatch($sformatf("integer_divisor got %0d expected %0d",
                                      got.integer_divisor, want.integer_divisor));
         if (got.frac_mul !== want.frac_mul)
            report_mismatch($sformatf("frac_mul got %0d expected %0d",
                                      got.frac_mul, want.frac_mul));
         if (got.frac_divadd !== want.frac_divadd)
            report_mismatch($sformatf("frac_divadd got %0d expected %0d",
                                      got.frac_divadd, want.frac_divadd));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [CLK_W-1:0] csr_wr_data;
   logic [CLK_W-1:0] clock_hz;
   bit quiet = 1'b0;
   int stall_cycles = 0;
   baud_divisor_scoreboard sb;

   ufbd_req_if req_if ();
   ufbd_rsp_if rsp_if ();

   uart_fractional_baud_divisor_search_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mostly plausible rates, some exact divisions of clock/16, some raw or tiny values
   function automatic logic [BAUD_W-1:0] pick_baud(input logic [CLK_W-1:0] clk_hz);
      int unsigned sel;
      int unsigned k;
      int unsigned e;
      int unsigned tries;
      logic [31:0] base;
      int unsigned common_bauds[14] = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600,
                                        115200, 230400, 460800, 921600, 1000000, 3000000};
      sel = $urandom_range(0, 99);
      base = 32'(clk_hz >> 4);
      if (sel < 10)
         return BAUD_W'($urandom);
      if (sel < 18)
         return BAUD_W'($urandom_range(0, 299));
      if (sel < 35 && base != 0) begin
         for (tries = 0; tries < 8; tries++) begin
            k = $urandom_range(1, 255);
            if (base % k == 0 && base / k < 32'h0100_0000)
               return BAUD_W'(base / k);
         end
      end
      if (sel < 50)
         return BAUD_W'(common_bauds[$urandom_range(0, 13)]);
      e = $urandom_range(9, 24);
      return BAUD_W'($urandom_range((1 << e) - 1, 1 << (e - 1)));
   endfunction

   task automatic send_baud(input logic [BAUD_W-1:0] baud);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.baud_rate <= baud;
      do @(posedge clock); while (!req_if.ready);
      sb.note_baud_request(clock_hz, baud);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_clock(input logic [CLK_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      clock_hz = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin : result_sink
      int gap;
      result_type got;
      rsp_if.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 9);
         repeat (gap) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got.integer_divisor = rsp_if.integer_divisor;
         got.frac_mul = rsp_if.frac_mul;
         got.frac_divadd = rsp_if.frac_divadd;
         sb.check_divisor_result(got);
      end
   end

   // cycles without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [CLK_W-1:0] phase_clock[8];
      int phase;
      int n;
      sb = new();
      req_if.valid = 1'b0;
      req_if.baud_rate = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      clock_hz = CLK_RESET;
      phase_clock = '{CLK_RESET, 29'h1FFF_FFFF, 29'd0, 29'd12000000, 29'd1000,
                      CLK_W'($urandom_range(0, 32'h1FFF_FFFF)), 29'd48000000, CLK_RESET};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 8; phase++) begin
         if (phase != 0) begin
            wait_drained();
            write_clock(phase_clock[phase]);
         end
         quiet = (phase == 3 || phase == 6);
         case (phase)
            0: begin
               send_baud(24'd0);
               send_baud(24'd1);
               send_baud(24'd299);
               send_baud(24'd300);
               send_baud(24'hFFFFFF);
               send_baud(24'd9600);
               send_baud(24'd115200);
               // exact ratios where baud divides clock/16, plus bit-pattern rates that do not
               send_baud(24'd12750000);
               send_baud(24'd6375000);
               send_baud(24'd750000);
               send_baud(24'h555555);
               send_baud(24'hAAAAAA);
               send_baud(24'h800000);
               send_baud(24'd3187500);
            end
            1: begin
               send_baud(24'd0);
               send_baud(24'd1);
               send_baud(24'hFFFFFF);
            end
            2: begin
               // zero clock gives a zero ratio unless the baud rate is zero
               send_baud(24'd9600);
               send_baud(24'd0);
            end
            4: begin
               send_baud(24'd100);
               send_baud(24'hFFFFFF);
            end
            default: ;
         endcase
         for (n = 0; n < 15; n++) begin
            if (phase == 1 && n == 9)
               wait_drained();
            send_baud(pick_baud(clock_hz));
         end
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ufbd_pkg.sv
rtl/core/ufbd_req_if.sv
rtl/core/ufbd_rsp_if.sv
rtl/core/ufbd_div.sv
rtl/core/ufbd_ctrl.sv
rtl/core/uart_fractional_baud_divisor_search_top.sv
dv/testbench.sv
